// File: src/grid_point_collision_legalizer_macros.svh
// Assertion macros used by the grid point collision legalizer checker
`ifndef GRID_POINT_COLLISION_LEGALIZER_MACROS_SVH
`define GRID_POINT_COLLISION_LEGALIZER_MACROS_SVH

// same-cycle implication
`define GPCL_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GPCL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/gpcl_pkg.sv
// Shared types, codes and constants of the grid point collision legalizer
package gpcl_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int COORD_W      = 32;
	localparam int MOVABLE_W    = 7;
	localparam int STATUS_W     = 3;
	localparam int OP_W         = 2;
	localparam int REG_IDX_W    = 3;

	localparam logic [REG_IDX_W-1:0] REG_CORE_X_LOW     = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_CORE_Y_LOW     = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_CORE_X_HIGH    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_CORE_Y_HIGH    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_MOVABLE_COUNT  = 3'd4;

	typedef enum logic [OP_W-1:0] {
		OP_FIXED = 2'd0,
		OP_MOVE  = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_FIXED   = 3'd0,
		ST_KEPT    = 3'd1,
		ST_MOVED   = 3'd2,
		ST_DUP     = 3'd3,
		ST_FAIL    = 3'd4,
		ST_FULL    = 3'd5,
		ST_CLEARED = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_STEP,
		S_PROBE,
		S_FINISH
	} state_t;

	typedef struct packed {
		status_t status;
		logic    record;
		logic    fixed;
		logic    clear;
		logic    use_cand;
	} res_t;

	typedef struct packed {
		logic load;
		logic scan_start;
		logic cand_first;
		logic cand_next;
		logic emit;
		res_t res;
	} dp_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            full;
		logic            scan_done;
		logic            scan_hit;
		logic            in_box;
		logic            step_over;
		logic            out_free;
	} dp_stat_t;

endpackage

// File: src/gpcl_datapath.sv
// Datapath: configuration, point store, membership scan, candidate generation, result beat
module gpcl_datapath #(
	parameter int CAPACITY = gpcl_pkg::CAPACITY_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  gpcl_pkg::dp_cmd_t                      cmd,
	output gpcl_pkg::dp_stat_t                     stat,
	input  logic [gpcl_pkg::OP_W-1:0]              operation,
	input  logic signed [gpcl_pkg::COORD_W-1:0]    point_x,
	input  logic signed [gpcl_pkg::COORD_W-1:0]    point_y,
	input  logic                                   wr_en,
	input  logic [gpcl_pkg::REG_IDX_W-1:0]         wr_index,
	input  logic [gpcl_pkg::COORD_W-1:0]           wr_data,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [gpcl_pkg::COORD_W-1:0]    placed_x,
	output logic signed [gpcl_pkg::COORD_W-1:0]    placed_y,
	output logic [gpcl_pkg::STATUS_W-1:0]          status
);
	import gpcl_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int LW = ((CW > MOVABLE_W) ? CW : MOVABLE_W) + 1;
	localparam int EW = COORD_W + 2;

	localparam logic [1:0] DIR_POS_X = 2'd0;
	localparam logic [1:0] DIR_NEG_X = 2'd1;
	localparam logic [1:0] DIR_POS_Y = 2'd2;
	localparam logic [1:0] DIR_NEG_Y = 2'd3;

	logic signed [COORD_W-1:0] core_x_low_q, core_y_low_q, core_x_high_q, core_y_high_q;
	logic [MOVABLE_W-1:0]      movable_q;

	logic [OP_W-1:0]           op_q;
	logic signed [EW-1:0]      pt_x_q, pt_y_q;
	logic signed [EW-1:0]      cand_x_q, cand_y_q;
	logic [LW-1:0]             step_q;
	logic [1:0]                dir_q;

	logic [CW-1:0]             idx_q;
	logic                      rd_v_s1;
	logic [2*COORD_W-1:0]      rd_s1;
	logic                      hit_q;

	logic [CW-1:0]             used_q, fixed_q;
	logic [2*COORD_W-1:0]      mem_q [CAPACITY];

	logic                      out_valid_q;
	logic signed [COORD_W-1:0] placed_x_q, placed_y_q;
	logic [STATUS_W-1:0]       status_q;

	logic [LW-1:0]             nstep;
	logic [1:0]                ndir;
	logic signed [EW-1:0]      off, nx, ny;
	logic signed [EW-1:0]      rd_x_ext, rd_y_ext;
	logic                      match;
	logic [LW-1:0]             limit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			core_x_low_q  <= '0;
			core_y_low_q  <= '0;
			core_x_high_q <= {1'b0, {(COORD_W-1){1'b1}}};
			core_y_high_q <= {1'b0, {(COORD_W-1){1'b1}}};
			movable_q     <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_CORE_X_LOW:    core_x_low_q  <= wr_data;
				REG_CORE_Y_LOW:    core_y_low_q  <= wr_data;
				REG_CORE_X_HIGH:   core_x_high_q <= wr_data;
				REG_CORE_Y_HIGH:   core_y_high_q <= wr_data;
				REG_MOVABLE_COUNT: movable_q     <= wr_data[MOVABLE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (cmd.cand_first) begin
			nstep = LW'(1);
			ndir  = DIR_POS_X;
		end else if (dir_q == DIR_NEG_Y) begin
			nstep = step_q + 1'b1;
			ndir  = DIR_POS_X;
		end else begin
			nstep = step_q;
			ndir  = dir_q + 1'b1;
		end
		off = $signed(EW'(nstep));
		nx  = pt_x_q;
		ny  = pt_y_q;
		case (ndir)
			DIR_POS_X: nx = pt_x_q + off;
			DIR_NEG_X: nx = pt_x_q - off;
			DIR_POS_Y: ny = pt_y_q + off;
			default:   ny = pt_y_q - off;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= operation;
			pt_x_q   <= EW'(point_x);
			pt_y_q   <= EW'(point_y);
			cand_x_q <= EW'(point_x);
			cand_y_q <= EW'(point_y);
		end else if (cmd.cand_first || cmd.cand_next) begin
			cand_x_q <= nx;
			cand_y_q <= ny;
			step_q   <= nstep;
			dir_q    <= ndir;
		end
	end

	assign rd_x_ext = EW'($signed(rd_s1[2*COORD_W-1:COORD_W]));
	assign rd_y_ext = EW'($signed(rd_s1[COORD_W-1:0]));
	assign match    = rd_v_s1 && (rd_x_ext == cand_x_q) && (rd_y_ext == cand_y_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			rd_v_s1 <= 1'b0;
			hit_q   <= 1'b0;
		end else if (cmd.load || cmd.scan_start) begin
			idx_q   <= '0;
			rd_v_s1 <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			if (idx_q < used_q) begin
				idx_q   <= idx_q + 1'b1;
				rd_v_s1 <= 1'b1;
			end else begin
				rd_v_s1 <= 1'b0;
			end
			if (match) begin
				hit_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit && cmd.res.record) begin
			mem_q[used_q[AW-1:0]] <= {cand_x_q[COORD_W-1:0], cand_y_q[COORD_W-1:0]};
		end
		rd_s1 <= mem_q[idx_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			fixed_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.emit) begin
				if (cmd.res.clear) begin
					used_q  <= '0;
					fixed_q <= '0;
				end else begin
					if (cmd.res.record) begin
						used_q <= used_q + 1'b1;
					end
					if (cmd.res.fixed) begin
						fixed_q <= fixed_q + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			placed_x_q <= cmd.res.use_cand ? cand_x_q[COORD_W-1:0] : pt_x_q[COORD_W-1:0];
			placed_y_q <= cmd.res.use_cand ? cand_y_q[COORD_W-1:0] : pt_y_q[COORD_W-1:0];
			status_q   <= cmd.res.status;
		end
	end

	assign limit = LW'(movable_q) + LW'(fixed_q);

	always_comb begin
		stat.op        = op_q;
		stat.full      = (used_q == CW'(CAPACITY));
		stat.scan_done = hit_q || ((idx_q == used_q) && !rd_v_s1);
		stat.scan_hit  = hit_q;
		stat.in_box    = (cand_x_q >= EW'(core_x_low_q)) && (cand_x_q <= EW'(core_x_high_q)) &&
		                 (cand_y_q >= EW'(core_y_low_q)) && (cand_y_q <= EW'(core_y_high_q));
		stat.step_over = (step_q > limit);
		stat.out_free  = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign placed_x  = placed_x_q;
	assign placed_y  = placed_y_q;
	assign status    = status_q;

endmodule

// File: src/gpcl_ctrl.sv
// Controller: sequences check, candidate search and result beat for one item
module gpcl_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  gpcl_pkg::dp_stat_t stat,
	output gpcl_pkg::dp_cmd_t  cmd
);
	import gpcl_pkg::*;

	state_t state_q, state_d;
	res_t   res_q, res_d;

	function automatic res_t mk_res(status_t st, logic rec, logic fx, logic clr, logic uc);
		res_t r;
		r.status   = st;
		r.record   = rec;
		r.fixed    = fx;
		r.clear    = clr;
		r.use_cand = uc;
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_q   <= mk_res(ST_FAIL, 1'b0, 1'b0, 1'b0, 1'b0);
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		res_d    = res_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.res  = res_q;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				case (stat.op)
					OP_CLEAR: begin
						res_d   = mk_res(ST_CLEARED, 1'b0, 1'b0, 1'b1, 1'b0);
						state_d = S_FINISH;
					end
					OP_FIXED: begin
						if (stat.scan_done) begin
							if (stat.scan_hit) begin
								res_d = mk_res(ST_DUP, 1'b0, 1'b0, 1'b0, 1'b0);
							end else if (stat.full) begin
								res_d = mk_res(ST_FULL, 1'b0, 1'b0, 1'b0, 1'b0);
							end else begin
								res_d = mk_res(ST_FIXED, 1'b1, 1'b1, 1'b0, 1'b0);
							end
							state_d = S_FINISH;
						end
					end
					OP_MOVE: begin
						if (stat.full) begin
							res_d   = mk_res(ST_FULL, 1'b0, 1'b0, 1'b0, 1'b0);
							state_d = S_FINISH;
						end else if (stat.scan_done) begin
							if (!stat.scan_hit) begin
								res_d   = mk_res(ST_KEPT, 1'b1, 1'b0, 1'b0, 1'b0);
								state_d = S_FINISH;
							end else begin
								cmd.cand_first = 1'b1;
								state_d        = S_STEP;
							end
						end
					end
					default: begin
						res_d   = mk_res(ST_FAIL, 1'b0, 1'b0, 1'b0, 1'b0);
						state_d = S_FINISH;
					end
				endcase
			end
			S_STEP: begin
				if (stat.step_over) begin
					res_d   = mk_res(ST_FAIL, 1'b0, 1'b0, 1'b0, 1'b0);
					state_d = S_FINISH;
				end else if (stat.in_box) begin
					cmd.scan_start = 1'b1;
					state_d        = S_PROBE;
				end else begin
					cmd.cand_next = 1'b1;
				end
			end
			S_PROBE: begin
				if (stat.scan_done) begin
					if (stat.scan_hit) begin
						cmd.cand_next = 1'b1;
						state_d       = S_STEP;
					end else begin
						res_d   = mk_res(ST_MOVED, 1'b1, 1'b0, 1'b0, 1'b1);
						state_d = S_FINISH;
					end
				end
			end
			S_FINISH: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// File: src/grid_point_collision_legalizer.sv
// A fixed or kept point takes one membership scan of the stored points; a clear, an unused
// code or a movable point on a full store takes none. The result beat is raised as the
// block turns ready for the next item. A moved point adds one scan for each in-box candidate
// and none for each candidate outside the core box; one item is in work at a time.
// The membership scan reads one stored point per cycle from one read port.
// Reset clears counts, config registers, control; stored points stay undefined, no clearing pass.
module grid_point_collision_legalizer #(
	parameter int CAPACITY = gpcl_pkg::CAPACITY_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [gpcl_pkg::OP_W-1:0]           operation,
	input  logic signed [gpcl_pkg::COORD_W-1:0] point_x,
	input  logic signed [gpcl_pkg::COORD_W-1:0] point_y,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [gpcl_pkg::COORD_W-1:0] placed_x,
	output logic signed [gpcl_pkg::COORD_W-1:0] placed_y,
	output logic [gpcl_pkg::STATUS_W-1:0]       status,
	input  logic                                wr_en,
	input  logic [gpcl_pkg::REG_IDX_W-1:0]      wr_index,
	input  logic [gpcl_pkg::COORD_W-1:0]        wr_data
);
	import gpcl_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	gpcl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	gpcl_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.operation (operation),
		.point_x   (point_x),
		.point_y   (point_y),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.placed_x  (placed_x),
		.placed_y  (placed_y),
		.status    (status)
	);

endmodule

// File: src/gpcl_checker.sv
// Port checker of the grid point collision legalizer and its bind
`include "grid_point_collision_legalizer_macros.svh"

module gpcl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] placed_x,
	input logic [31:0] placed_y,
	input logic [2:0]  status
);

	`GPCL_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(placed_x) && $stable(placed_y) && $stable(status), "result beat changed before it was taken")

	`GPCL_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready, "input taken again in the cycle after a beat")

	`GPCL_ASSERT_SAME(a_result_while_busy, clk, arst_n, $rose(out_valid), !$past(in_ready), "result beat raised while the block stood idle")

endmodule

bind grid_point_collision_legalizer gpcl_checker u_gpcl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.placed_x  (placed_x),
	.placed_y  (placed_y),
	.status    (status)
);

// File: tb/tb_grid_point_collision_legalizer.sv
`timescale 1ns / 1ps
// Testbench: grid point collision legalizer driven with directed and random point streams
module tb_grid_point_collision_legalizer;
	import gpcl_pkg::*;

	localparam int                        CAPACITY     = CAPACITY_DEF;
	localparam logic [OP_W-1:0]           OP_UNUSED    = 2'd3;
	localparam logic signed [COORD_W-1:0] COORD_MIN    = 32'sh8000_0000;
	localparam logic signed [COORD_W-1:0] COORD_MAX    = 32'sh7fff_ffff;
	localparam int                        IDLE_PCT     = 34;
	localparam int                        STALL_LIMIT  = 200000;
	localparam int                        DRAIN_CYCLES = 20;
	localparam int                        ITEM_TARGET  = 550;
	localparam int                        REPORT_LIMIT = 64;
	localparam int                        DUE_AW       = 6;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		status_t                   st;
	} placement_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        in_valid = 1'b0;
	logic                        in_ready;
	logic [OP_W-1:0]             operation = OP_FIXED;
	logic signed [COORD_W-1:0]   point_x = '0;
	logic signed [COORD_W-1:0]   point_y = '0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic signed [COORD_W-1:0]   placed_x;
	logic signed [COORD_W-1:0]   placed_y;
	logic [STATUS_W-1:0]         status;
	logic                        wr_en = 1'b0;
	logic [REG_IDX_W-1:0]        wr_index = REG_CORE_X_LOW;
	logic [COORD_W-1:0]          wr_data = '0;

	// store model and its settings
	longint      box_xl = 0;
	longint      box_yl = 0;
	longint      box_xh = 64'sd2147483647;
	longint      box_yh = 64'sd2147483647;
	int          batch_movables = 0;
	longint      stored_x [CAPACITY];
	longint      stored_y [CAPACITY];
	bit          stored_ok [CAPACITY];
	int          fixed_total = 0;
	int          used_total = 0;

	placement_t        due_ring [1 << DUE_AW];
	logic [DUE_AW-1:0] due_head = '0;
	logic [DUE_AW-1:0] due_tail = '0;
	int          failures = 0;
	int          items_sent = 0;
	int          quiet_cycles = 0;
	bit          calm = 1'b0;

	grid_point_collision_legalizer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.point_x   (point_x),
		.point_y   (point_y),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.placed_x  (placed_x),
		.placed_y  (placed_y),
		.status    (status),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data)
	);

	always #2 clk = ~clk;

	function automatic bit point_taken(longint x, longint y);
		for (int i = 0; i < CAPACITY; i++)
			if (stored_ok[i] && stored_x[i] == x && stored_y[i] == y)
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic bit in_box(longint x, longint y);
		return x >= box_xl && x <= box_xh && y >= box_yl && y <= box_yh;
	endfunction

	function automatic logic signed [COORD_W-1:0] clamp_coord(longint v);
		if (v > 64'sd2147483647)
			return COORD_MAX;
		if (v < -64'sd2147483648)
			return COORD_MIN;
		return v[COORD_W-1:0];
	endfunction

	function automatic int idle_gap();
		int n;
		n = 0;
		if (!calm)
			while ($urandom_range(99) < IDLE_PCT)
				n++;
		return n;
	endfunction

	task automatic store_point(longint x, longint y);
		if (used_total < CAPACITY) begin
			stored_x[used_total] = x;
			stored_y[used_total] = y;
			stored_ok[used_total] = 1'b1;
			used_total++;
		end
	endtask

	task automatic legalize_point(logic [OP_W-1:0] op, logic signed [COORD_W-1:0] px,
			logic signed [COORD_W-1:0] py);
		longint     x, y, cx, cy, rx, ry;
		int         step_limit;
		bit         found;
		status_t    st;
		placement_t p;
		x = px;
		y = py;
		rx = x;
		ry = y;
		found = 1'b0;
		st = ST_FAIL;
		case (op)
			OP_FIXED: begin
				if (point_taken(x, y))
					st = ST_DUP;
				else if (used_total >= CAPACITY)
					st = ST_FULL;
				else begin
					store_point(x, y);
					fixed_total++;
					st = ST_FIXED;
				end
			end
			OP_MOVE: begin
				if (used_total >= CAPACITY)
					st = ST_FULL;
				else if (!point_taken(x, y)) begin
					store_point(x, y);
					st = ST_KEPT;
				end else begin
					step_limit = batch_movables + fixed_total;
					for (int s = 1; s <= step_limit && !found; s++)
						for (int d = 0; d < 4 && !found; d++) begin
							cx = x;
							cy = y;
							// try +x, -x, +y, -y
							case (d)
								0: cx = x + s;
								1: cx = x - s;
								2: cy = y + s;
								default: cy = y - s;
							endcase
							if (in_box(cx, cy) && !point_taken(cx, cy)) begin
								rx = cx;
								ry = cy;
								found = 1'b1;
							end
						end
					if (found) begin
						store_point(rx, ry);
						st = ST_MOVED;
					end
				end
			end
			OP_CLEAR: begin
				for (int i = 0; i < CAPACITY; i++)
					stored_ok[i] = 1'b0;
				fixed_total = 0;
				used_total = 0;
				st = ST_CLEARED;
			end
			default: st = ST_FAIL;
		endcase
		p.x = rx[COORD_W-1:0];
		p.y = ry[COORD_W-1:0];
		p.st = st;
		due_ring[due_tail] = p;
		due_tail++;
	endtask

	task automatic send_point(logic [OP_W-1:0] op, logic signed [COORD_W-1:0] x,
			logic signed [COORD_W-1:0] y);
		int gap;
		gap = idle_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		point_x <= x;
		point_y <= y;
		do
			@(posedge clk);
		while (!in_ready);
		legalize_point(op, x, y);
		items_sent++;
	endtask

	task automatic send_near(logic [OP_W-1:0] op, logic signed [COORD_W-1:0] cx,
			logic signed [COORD_W-1:0] cy, int spread);
		longint ox, oy;
		ox = longint'(cx) + int'($urandom_range(0, 2 * spread)) - spread;
		oy = longint'(cy) + int'($urandom_range(0, 2 * spread)) - spread;
		send_point(op, clamp_coord(ox), clamp_coord(oy));
	endtask

	task automatic send_batch_item(logic [OP_W-1:0] op, logic signed [COORD_W-1:0] cx,
			logic signed [COORD_W-1:0] cy, int spread);
		int roll;
		roll = $urandom_range(99);
		if (roll < 3)
			send_point(OP_UNUSED, $urandom(), $urandom());
		else if (roll < 5)
			send_point(OP_CLEAR, $urandom(), $urandom());
		else if (roll < 10)
			send_point(op, $urandom(), $urandom());
		else
			send_near(op, cx, cy, spread);
	endtask

	// hold the sender until every result is back
	task automatic drain_results();
		in_valid <= 1'b0;
		while (due_head != due_tail)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [COORD_W-1:0] data);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			REG_CORE_X_LOW:    box_xl = $signed(data);
			REG_CORE_Y_LOW:    box_yl = $signed(data);
			REG_CORE_X_HIGH:   box_xh = $signed(data);
			REG_CORE_Y_HIGH:   box_yh = $signed(data);
			REG_MOVABLE_COUNT: batch_movables = data[MOVABLE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_core_box(logic signed [COORD_W-1:0] xl, logic signed [COORD_W-1:0] yl,
			logic signed [COORD_W-1:0] xh, logic signed [COORD_W-1:0] yh, int movables);
		write_reg(REG_CORE_X_LOW, xl);
		write_reg(REG_CORE_Y_LOW, yl);
		write_reg(REG_CORE_X_HIGH, xh);
		write_reg(REG_CORE_Y_HIGH, yh);
		write_reg(REG_MOVABLE_COUNT, movables);
	endtask

	function automatic logic signed [COORD_W-1:0] pick_centre();
		case ($urandom_range(0, 4))
			0: return COORD_MIN + $urandom_range(0, 3);
			1: return COORD_MAX - $urandom_range(0, 3);
			2: return $urandom();
			default: return $urandom_range(0, 40) - 20;
		endcase
	endfunction

	task automatic test_basic_ops();
		send_point(OP_FIXED, 0, 0);
		send_point(OP_FIXED, 0, 0);
		send_point(OP_MOVE, 0, 0);
		send_point(OP_MOVE, -5, -5);
		send_point(OP_MOVE, -5, -5);
		send_point(OP_UNUSED, 7, -9);
		send_point(OP_CLEAR, 3, 4);
	endtask

	task automatic test_core_box();
		drain_results();
		set_core_box(10, 20, 12, 22, 1);
		for (int r = REG_MOVABLE_COUNT + 1; r < (1 << REG_IDX_W); r++)
			write_reg(REG_IDX_W'(r), $urandom());
		send_point(OP_CLEAR, 0, 0);
		send_point(OP_FIXED, 11, 21);
		repeat (5) send_point(OP_MOVE, 11, 21);
		drain_results();
		set_core_box(5, 20, 4, 22, 1);
		send_point(OP_MOVE, 11, 21);
	endtask

	task automatic test_wide_coords();
		drain_results();
		set_core_box(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 0);
		send_point(OP_CLEAR, COORD_MAX, COORD_MIN);
		send_point(OP_FIXED, COORD_MIN, 0);
		send_point(OP_FIXED, COORD_MIN + 1, 0);
		send_point(OP_MOVE, COORD_MIN, 0);
		send_point(OP_FIXED, COORD_MAX, COORD_MAX);
		send_point(OP_MOVE, COORD_MAX, COORD_MAX);
		send_point(OP_MOVE, COORD_MIN, COORD_MIN);
		send_point(OP_MOVE, COORD_MAX, COORD_MIN);
	endtask

	task automatic test_store_full();
		logic signed [COORD_W-1:0] cx, cy;
		drain_results();
		set_core_box(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, $urandom_range(0, 64));
		send_point(OP_CLEAR, $urandom(), $urandom());
		cx = pick_centre();
		cy = pick_centre();
		repeat (24) send_near(OP_FIXED, cx, cy, 5);
		repeat (50) send_near(OP_MOVE, cx, cy, 5);
		repeat (6) send_near(OP_FIXED, cx, cy, 5);
	endtask

	task automatic test_random_batches();
		logic signed [COORD_W-1:0] cx, cy, xl, yl, xh, yh;
		int                        batch, spread, movables, roll;
		batch = 0;
		while (items_sent < ITEM_TARGET - 10) begin
			drain_results();
			calm = (batch == 2 || batch == 3);
			cx = pick_centre();
			cy = pick_centre();
			spread = $urandom_range(0, 3);
			xl = COORD_MIN;
			yl = COORD_MIN;
			xh = COORD_MAX;
			yh = COORD_MAX;
			case ($urandom_range(0, 4))
				0: ;
				1: begin
					xl = clamp_coord(longint'(cx) - $urandom_range(1, 6));
					xh = clamp_coord(longint'(cx) + $urandom_range(1, 6));
					yl = clamp_coord(longint'(cy) - $urandom_range(1, 6));
					yh = clamp_coord(longint'(cy) + $urandom_range(1, 6));
				end
				2: begin
					xl = 0;
					yl = 0;
					cx = $urandom_range(0, 6);
					cy = $urandom_range(0, 6);
				end
				3: begin
					if ($urandom_range(1)) begin
						xl = COORD_MAX;
						xh = COORD_MIN;
					end else begin
						yl = clamp_coord(longint'(cy) + 2);
						yh = clamp_coord(longint'(cy) - 2);
					end
				end
				default: begin
					xl = cx;
					xh = clamp_coord(longint'(cx) + 4);
					yl = clamp_coord(longint'(cy) - 4);
					yh = cy;
				end
			endcase
			roll = $urandom_range(99);
			movables = (roll < 10) ? 64 : (roll < 20) ? 0 : $urandom_range(1, 8);
			set_core_box(xl, yl, xh, yh, movables);
			if ($urandom_range(3) == 0)
				write_reg(REG_IDX_W'(REG_MOVABLE_COUNT + 1 + $urandom_range(0, 2)), $urandom());
			if ($urandom_range(9) != 0)
				send_point(OP_CLEAR, $urandom(), $urandom());
			repeat ($urandom_range(0, 5)) send_batch_item(OP_FIXED, cx, cy, spread);
			repeat ($urandom_range(2, 24)) send_batch_item(OP_MOVE, cx, cy, spread);
			batch++;
		end
		calm = 1'b0;
	endtask

	always @(posedge clk) begin
		out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
	end

	always @(posedge clk) begin : check_results
		placement_t want;
		if (arst_n && out_valid && out_ready) begin
			if (due_head == due_tail) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$error("unexpected beat: placed_x %0d placed_y %0d status %0d",
						placed_x, placed_y, status);
			end else begin
				want = due_ring[due_head];
				due_head++;
				if (placed_x !== want.x || placed_y !== want.y || status !== want.st) begin
					failures++;
					if (failures <= REPORT_LIMIT) begin
						if (placed_x !== want.x)
							$error("placed_x: expected %0d, got %0d", want.x, placed_x);
						if (placed_y !== want.y)
							$error("placed_y: expected %0d, got %0d", want.y, placed_y);
						if (status !== want.st)
							$error("status: expected %0d, got %0d", want.st, status);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_ops();
		test_core_box();
		test_wide_coords();
		test_store_full();
		test_random_batches();
		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
